// ===== sv/atbd_pkg.sv =====
`default_nettype none
package atbd_pkg;

   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 32;
   localparam int unsigned REQ_DAT_W = 48;
   localparam int unsigned RSP_DAT_W = 56;

   localparam logic [TIME_W-1:0] BOOT_DELAY_MS_DEF = 32'd1000;

   localparam logic [SAMPLE_W-1:0] MIN_RESET  = 16'hFFFF;
   localparam logic [SAMPLE_W-1:0] MAX_RESET  = 16'h0000;
   localparam logic [SAMPLE_W-1:0] SENS_RESET = 16'h8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AUTO_MODE    = 3'd0,
      CSR_MANUAL_THR   = 3'd1,
      CSR_SENSITIVITY  = 3'd2,
      CSR_MIN_RANGE    = 3'd3,
      CSR_TIMEOUT      = 3'd4,
      CSR_POLARITY     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                auto_mode;
      logic [SAMPLE_W-1:0] manual_threshold;
      logic [SAMPLE_W-1:0] sensitivity_q16;
      logic [SAMPLE_W-1:0] minimum_range;
      logic                blocked_when_high;
   } decide_cfg_type;

   typedef struct packed {
      logic                cur;
      logic [SAMPLE_W-1:0] threshold;
   } decide_res_type;

endpackage
`default_nettype wire

// ===== sv/atbd_decide.sv =====
`default_nettype none
module atbd_decide (
   input  wire atbd_pkg::decide_cfg_type       cfg,
   input  wire logic [atbd_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic [atbd_pkg::SAMPLE_W-1:0]  tracked_min,
   input  wire logic [atbd_pkg::SAMPLE_W-1:0]  tracked_max,
   output atbd_pkg::decide_res_type            res
);

   logic [atbd_pkg::SAMPLE_W-1:0]   range;
   logic [2*atbd_pkg::SAMPLE_W-1:0] product;
   logic [atbd_pkg::SAMPLE_W-1:0]   thr;
   logic                            range_ok;
   logic                            above;

   always_comb begin
      range    = tracked_max - tracked_min;
      product  = range * cfg.sensitivity_q16;
      if (cfg.auto_mode) begin
         thr = tracked_min + product[2*atbd_pkg::SAMPLE_W-1:atbd_pkg::SAMPLE_W];
      end else begin
         thr = cfg.manual_threshold;
      end
      range_ok = (range >= cfg.minimum_range) || !cfg.auto_mode;
      above    = sample >= thr;
      res.cur       = range_ok & (above ^ ~cfg.blocked_when_high);
      res.threshold = thr;
   end

endmodule
`default_nettype wire

// ===== sv/adaptive_threshold_beam_detector_top.sv =====
// Channel  | Ports     | tdata fields, lowest bit up
// req      | req_t*    | sample[15:0], now_ms[47:16]
// rsp      | rsp_t*    | blocked[0], changed[1], tracked_min[17:2], tracked_max[33:18],
//          |           | threshold_used[49:34], zero[55:50]
// csr      | csr_*     | index 0..5, write data 32 bits
// One transaction per cycle while rsp is ready; req passes stage 1, then the output register.
// Stage 1 updates min/max and their deadlines on accept; stage 2 forms the
// threshold (multiply and add in auto mode) and the decision into the output register.
// Synchronous reset restores config, tracking state and valid flags; no clearing pass.
// A stalled rsp holds both stages; req_tready drops only when both are full.
`default_nettype none
module adaptive_threshold_beam_detector_top #(
   parameter logic [atbd_pkg::TIME_W-1:0] BOOT_DELAY_MS = atbd_pkg::BOOT_DELAY_MS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [atbd_pkg::REQ_DAT_W-1:0]    req_tdata,  // sample, now_ms
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [atbd_pkg::RSP_DAT_W-1:0]         rsp_tdata,  // blocked, changed, min, max, thr
   input  wire logic                              csr_we,
   input  wire logic [atbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [atbd_pkg::CSR_DAT_W-1:0]    csr_wdata
);

   localparam int unsigned SW = atbd_pkg::SAMPLE_W;
   localparam int unsigned TW = atbd_pkg::TIME_W;

   atbd_pkg::decide_cfg_type cfg_ff;
   logic [TW-1:0]            timeout_ff;

   logic [SW-1:0] run_min_ff, run_min_in;
   logic [SW-1:0] run_max_ff, run_max_in;
   logic [TW-1:0] min_dl_ff, min_dl_in;
   logic [TW-1:0] max_dl_ff, max_dl_in;
   logic          beam_ff;

   logic          s1_valid_ff;
   logic [SW-1:0] s1_sample_ff;
   logic [SW-1:0] s1_min_ff;
   logic [SW-1:0] s1_max_ff;

   logic          out_valid_ff;
   logic [atbd_pkg::RSP_DAT_W-1:0] out_data_ff;

   logic [SW-1:0] in_sample;
   logic [TW-1:0] in_now;
   logic [TW-1:0] new_dl;
   logic          timeout_on;
   logic          take_min;
   logic          take_max;
   logic          advance;
   logic          accept;
   atbd_pkg::decide_res_type dec;

   assign in_sample = req_tdata[SW-1:0];
   assign in_now    = req_tdata[SW+TW-1:SW];

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      timeout_on = timeout_ff != '0;
      new_dl     = in_now + timeout_ff;
      take_min   = (in_sample <= run_min_ff) || (timeout_on && (in_now > min_dl_ff));
      take_max   = (in_sample >= run_max_ff) || (timeout_on && (in_now > max_dl_ff));
      run_min_in = take_min ? in_sample : run_min_ff;
      min_dl_in  = take_min ? new_dl    : min_dl_ff;
      run_max_in = take_max ? in_sample : run_max_ff;
      max_dl_in  = take_max ? new_dl    : max_dl_ff;
   end

   atbd_decide u_decide (
      .cfg         (cfg_ff),
      .sample      (s1_sample_ff),
      .tracked_min (s1_min_ff),
      .tracked_max (s1_max_ff),
      .res         (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_mode         <= 1'b1;
         cfg_ff.manual_threshold  <= '0;
         cfg_ff.sensitivity_q16   <= atbd_pkg::SENS_RESET;
         cfg_ff.minimum_range     <= '0;
         cfg_ff.blocked_when_high <= 1'b1;
         timeout_ff               <= '0;
      end else if (csr_we) begin
         case (csr_index)
            atbd_pkg::CSR_AUTO_MODE:   cfg_ff.auto_mode         <= csr_wdata[0];
            atbd_pkg::CSR_MANUAL_THR:  cfg_ff.manual_threshold  <= csr_wdata[SW-1:0];
            atbd_pkg::CSR_SENSITIVITY: cfg_ff.sensitivity_q16   <= csr_wdata[SW-1:0];
            atbd_pkg::CSR_MIN_RANGE:   cfg_ff.minimum_range     <= csr_wdata[SW-1:0];
            atbd_pkg::CSR_TIMEOUT:     timeout_ff               <= csr_wdata[TW-1:0];
            atbd_pkg::CSR_POLARITY:    cfg_ff.blocked_when_high <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff   <= atbd_pkg::MIN_RESET;
         run_max_ff   <= atbd_pkg::MAX_RESET;
         min_dl_ff    <= BOOT_DELAY_MS;
         max_dl_ff    <= BOOT_DELAY_MS;
         beam_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            run_min_ff <= run_min_in;
            run_max_ff <= run_max_in;
            min_dl_ff  <= min_dl_in;
            max_dl_ff  <= max_dl_in;
         end
         if (advance) begin
            s1_valid_ff  <= accept;
            out_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               beam_ff <= dec.cur;
            end
         end else if (accept) begin
            s1_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= in_sample;
         s1_min_ff    <= run_min_in;
         s1_max_ff    <= run_max_in;
      end
      if (advance && s1_valid_ff) begin
         out_data_ff <= {6'b0, dec.threshold, s1_max_ff, s1_min_ff,
                         dec.cur ^ beam_ff, dec.cur};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

// ===== sv/atbd_checker.sv =====
`default_nettype none
module atbd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [atbd_pkg::RSP_DAT_W-1:0]    rsp_tdata
);

   logic prev_blocked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_blocked_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         prev_blocked_ff <= rsp_tdata[0];
      end
   end

   // changed must flag a difference from the blocked bit of the previous rsp transaction
   a_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> rsp_tdata[1] == (rsp_tdata[0] != prev_blocked_ff))
      else $error("changed flag inconsistent with previous blocked state");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled while rsp register is empty");

   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp appeared without a req two cycles earlier");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp changed");

endmodule

bind adaptive_threshold_beam_detector_top atbd_checker u_atbd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
